// File: rtl/pbtl_pkg.sv
package pbtl_pkg;
  localparam int PrioLevels = 32;
  localparam int TaskCount = 64;
  localparam int ListCount = 3;
  localparam logic [1:0] ListReady = 2'd0;
  localparam logic [1:0] ListDelayed = 2'd1;
  localparam logic [1:0] NoList = 2'd3;
  localparam logic [1:0] ListWait = 2'd2;

  localparam logic [1:0] ActAdd = 2'd0;
  localparam logic [1:0] ActRemove = 2'd1;
  localparam logic [1:0] ActTake = 2'd2;
  localparam logic [1:0] ActNone = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StBad = 2'd2;
endpackage

// File: rtl/pbtl_task_mem.sv
module pbtl_task_mem import pbtl_pkg::*; #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);
  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/priority_bitmap_task_lists.sv
// each item steps through states before its result is registered: a rejected item goes
// straight to the output, add reads and links the task, remove reads and unlinks it, and
// take scans levels downward (all if none match), walks occupied chains, unlinks a match
// next item accepted the cycle after the result is registered; a waiting result stalls it
// reset clears head/tail valid bits, membership valid bits and bitmaps at once
// result register holds until taken
module priority_bitmap_task_lists import pbtl_pkg::*; #(
  parameter int PRIORITY_LEVELS = PrioLevels,
  parameter int TASK_COUNT = TaskCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action, which_list, task_id, priority_req, event_id, zero fill
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, out_task, out_priority, list_bitmap, zero fill
  output logic [47:0] m_axis_tdata
);
  localparam int TW = $clog2(TASK_COUNT);
  localparam int PW = $clog2(PRIORITY_LEVELS);
  localparam int HD = ListCount * PRIORITY_LEVELS;
  localparam int HW = $clog2(HD);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_ADD, S_RM0, S_RM1, S_RM2, S_SCAN, S_FIRST, S_HEAD, S_NODE, S_NODE2,
    S_OUT
  } state_e;

  state_e state_q;
  logic [1:0] act_q, lst_q;
  logic [5:0] tid_in_q;
  logic [4:0] prio_in_q;
  logic [7:0] ev_q;
  logic [TASK_COUNT-1:0] mv_q;
  logic [PRIORITY_LEVELS-2:0] occ_q [ListCount];
  logic [HD-1:0] hv_q, tv_q;
  logic [TW-1:0] cur_q;
  logic [PW-1:0] p_q;
  logic [1:0] st_q;
  logic [5:0] otask_q;
  logic [4:0] oprio_q;
  logic [44:0] res_q;
  logic out_v_q;

  // per task memory: {member, prev valid, prev, next valid, next, prio, event}
  localparam int LW = 2 * (TW + 1) + PW + 8;
  localparam int MW = LW + 2;
  logic we;
  logic [TW-1:0] waddr, raddr;
  logic [MW-1:0] wdata, rdata;
  pbtl_task_mem #(.W(MW), .D(TASK_COUNT)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [1:0]     r_mb;
  logic           r_pv, r_nv;
  logic [TW-1:0]  r_p, r_n;
  logic [PW-1:0]  r_pr;
  logic [7:0]     r_ev;
  assign {r_mb, r_pv, r_p, r_nv, r_n, r_pr, r_ev} = rdata;

  // chain memory per list and priority: {head, tail}
  logic cwe;
  logic [HW-1:0] cwaddr, craddr;
  logic [2*TW-1:0] cwdata, crdata;
  pbtl_task_mem #(.W(2 * TW), .D(HD)) u_chain (
    .clk_i, .we_i(cwe), .waddr_i(cwaddr), .wdata_i(cwdata), .raddr_i(craddr),
    .rdata_o(crdata)
  );

  logic [TW-1:0] c_head, c_tail;
  assign {c_head, c_tail} = crdata;

  // second link memory write path is serialized via states
  logic [TW-1:0] tid;
  logic [HW-1:0] hidx, ridx, cidx;
  logic [1:0] member;
  assign tid = TW'(tid_in_q);
  assign hidx = HW'(lst_q * PRIORITY_LEVELS + prio_in_q);
  assign ridx = HW'(lst_q * PRIORITY_LEVELS + p_q);
  assign cidx = HW'(lst_q * PRIORITY_LEVELS + r_pr);
  assign member = mv_q[tid] ? r_mb : NoList;

  logic [MW-1:0] node_q;
  logic [31:0] occ_ext;
  always_comb begin
    occ_ext = '0;
    if (lst_q != NoList) occ_ext = 32'({occ_q[lst_q], 1'b0} >> 1);
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {3'b0, res_q};

  always_comb begin
    we = 1'b0; waddr = tid; wdata = '0; raddr = tid;
    unique case (state_q)
      S_IDLE: raddr = TW'(s_axis_tdata[9:4]);
      S_ADD: begin
        we = 1'b1; waddr = tid; raddr = c_tail;
        wdata = {lst_q, tv_q[hidx], c_tail, 1'b0, {TW{1'b0}}, PW'(prio_in_q), ev_q};
      end
      S_NODE2: begin
        we = 1'b1; waddr = cur_q;
        wdata = {r_mb, r_pv, r_p, 1'b1, tid, r_pr, r_ev};
      end
      S_RM0: raddr = r_p;
      S_RM1: begin
        raddr = node_q[LW-TW-3 -: TW];
        if (node_q[LW-1]) begin
          we = 1'b1; waddr = node_q[LW-2 -: TW];
          wdata = {r_mb, r_pv, r_p, node_q[LW-TW-2], node_q[LW-TW-3 -: TW], r_pr, r_ev};
        end
      end
      S_RM2: begin
        we = 1'b1; waddr = cur_q;
        wdata = {r_mb, node_q[LW-1], node_q[LW-2 -: TW], r_nv, r_n, r_pr, r_ev};
      end
      S_HEAD, S_NODE: raddr = cur_q;
      default: ;
    endcase
  end

  logic [HW-1:0] rmi;
  assign rmi = HW'(lst_q * PRIORITY_LEVELS + node_q[PW+7:8]);

  always_comb begin
    cwe = 1'b0; cwaddr = hidx; cwdata = {tid, tid}; craddr = hidx;
    unique case (state_q)
      S_ADD: begin
        cwe = 1'b1;
        cwdata = {tv_q[hidx] ? c_head : tid, tid};
      end
      S_RM0: craddr = cidx;
      S_RM1: begin
        cwe = !node_q[LW-1] || !node_q[LW-TW-2]; cwaddr = rmi;
        cwdata = {node_q[LW-1] ? c_head : node_q[LW-TW-3 -: TW],
                  node_q[LW-TW-2] ? c_tail : node_q[LW-2 -: TW]};
      end
      S_SCAN: craddr = ridx;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; out_v_q <= 1'b0; hv_q <= '0; tv_q <= '0; mv_q <= '0;
      for (int i = 0; i < ListCount; i++) occ_q[i] <= '0;
    end else begin
      if (out_v_q && m_axis_tready && state_q != S_OUT) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          {ev_q, prio_in_q, tid_in_q, lst_q, act_q} <= s_axis_tdata[22:0];
          state_q <= S_RD;
        end
        S_RD: begin
          st_q <= StBad; otask_q <= '0; oprio_q <= '0;
          state_q <= S_OUT;
          if (act_q == ActTake) begin
            lst_q <= ListWait; st_q <= StNotFound;
            p_q <= PW'(PRIORITY_LEVELS - 1); state_q <= S_SCAN;
          end else if ((act_q == ActAdd || act_q == ActRemove) && lst_q != NoList
                       && 32'(tid_in_q) < TASK_COUNT) begin
            if (act_q == ActAdd) begin
              if (prio_in_q != 0 && 32'(prio_in_q) < PRIORITY_LEVELS
                  && member == NoList) state_q <= S_ADD;
            end else if (member == lst_q) begin
              cur_q <= tid; state_q <= S_RM0;
            end else st_q <= StNotFound;
          end else if (act_q != ActAdd && act_q != ActRemove) begin
            lst_q <= NoList;
          end
        end
        S_ADD: begin
          if (tv_q[hidx]) begin
            cur_q <= c_tail; state_q <= S_NODE2;
          end else begin
            hv_q[hidx] <= 1'b1; state_q <= S_OUT;
          end
          tv_q[hidx] <= 1'b1;
          occ_q[lst_q][prio_in_q - 1] <= 1'b1;
          mv_q[tid] <= 1'b1; st_q <= StOk;
        end
        S_NODE2: begin
          state_q <= S_OUT;
        end
        S_RM0: begin
          node_q <= rdata; cur_q <= r_p; state_q <= S_RM1;
          st_q <= StOk; otask_q <= 6'(cur_q); oprio_q <= 5'(r_pr);
        end
        S_RM1: begin
          if (!node_q[LW-1]) begin
            hv_q[rmi] <= node_q[LW-TW-2];
            if (!node_q[LW-TW-2]) occ_q[lst_q][node_q[PW+7:8] - 1] <= 1'b0;
          end
          if (!node_q[LW-TW-2]) begin
            tv_q[rmi] <= node_q[LW-1];
            state_q <= S_OUT;
          end else begin
            cur_q <= node_q[LW-TW-3 -: TW]; state_q <= S_RM2;
          end
          mv_q[tid] <= 1'b0;
        end
        S_RM2: state_q <= S_OUT;
        S_SCAN: begin
          if (p_q == 0) state_q <= S_OUT;
          else if (occ_q[ListWait][p_q - 1] && hv_q[ridx]) state_q <= S_FIRST;
          else p_q <= p_q - 1'b1;
        end
        S_FIRST: begin
          cur_q <= c_head; state_q <= S_HEAD;
        end
        S_HEAD: state_q <= S_NODE;
        S_NODE: begin
          if (r_ev == ev_q) begin
            tid_in_q <= 6'(cur_q); cur_q <= cur_q; state_q <= S_RM0;
          end else if (r_nv) begin
            cur_q <= r_n; state_q <= S_HEAD;
          end else begin
            p_q <= p_q - 1'b1; state_q <= S_SCAN;
          end
        end
        S_OUT: if (!out_v_q || m_axis_tready) begin
          res_q <= {occ_ext, oprio_q, otask_q, st_q}; out_v_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
